// ----- design/mkvp_pkg.sv -----
package mkvp_pkg;

  localparam int NUM_KEYS    = 5;
  localparam int MAX_KEY_LEN = 13;
  localparam int KEY_POS_W   = 4;
  localparam int FIELD_ID_W  = 3;

  localparam logic [NUM_KEYS-1:0] ALL_KEYS = '1;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [7:0] KEY_TEXT [NUM_KEYS][MAX_KEY_LEN] = '{
    '{"M", "e", "m", "T", "o", "t", "a", "l", ":", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"M", "e", "m", "F", "r", "e", "e", ":", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"M", "e", "m", "A", "v", "a", "i", "l", "a", "b", "l", "e", ":"},
    '{"S", "w", "a", "p", "T", "o", "t", "a", "l", ":", 8'h00, 8'h00, 8'h00},
    '{"S", "w", "a", "p", "F", "r", "e", "e", ":", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [KEY_POS_W-1:0] KEY_LEN [NUM_KEYS] = '{
    4'd9, 4'd8, 4'd13, 4'd10, 4'd9
  };

  typedef enum logic [1:0] {
    PH_MATCH = 2'd0,
    PH_BLANK = 2'd1,
    PH_DIGIT = 2'd2,
    PH_SKIP  = 2'd3
  } phase_t;

  typedef struct packed {
    logic                  field_valid;
    logic [FIELD_ID_W-1:0] field_id;
    logic                  end_of_sample;
  } result_t;

endpackage

// ----- design/mkvp_in_stage.sv -----
module mkvp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last_byte,
  input  logic       advance,
  output logic       item_valid,
  output logic [7:0] item_byte,
  output logic       item_last
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       accept;

  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte;
      last_r <= in_last_byte;
    end
  end

  assign item_valid = valid_r;
  assign item_byte  = byte_r;
  assign item_last  = last_r;

endmodule

// ----- design/mkvp_parser.sv -----
module mkvp_parser #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  logic [7:0]             item_byte,
  input  logic                   item_last,
  output logic                   res_present,
  output mkvp_pkg::result_t      res,
  output logic [VALUE_WIDTH-1:0] res_value
);

  mkvp_pkg::phase_t                           phase_r, phase_nxt;
  logic [mkvp_pkg::KEY_POS_W-1:0]             kpos_r, kpos_nxt;
  logic [mkvp_pkg::NUM_KEYS-1:0]              cmask_r, cmask_nxt;
  logic [mkvp_pkg::FIELD_ID_W-1:0]            mkey_r, mkey_nxt;
  logic [VALUE_WIDTH-1:0]                     acc_r, acc_nxt;

  logic [mkvp_pkg::NUM_KEYS-1:0]              newmask;
  logic                                       done_any;
  logic [mkvp_pkg::FIELD_ID_W-1:0]            done_id;
  logic [mkvp_pkg::KEY_POS_W-1:0]             pos_idx;
  logic                                       is_nl;
  logic                                       is_blank;
  logic                                       is_digit;
  logic [VALUE_WIDTH-1:0]                     digit_ext;
  logic [VALUE_WIDTH-1:0]                     acc_step;
  logic                                       emit;
  logic [mkvp_pkg::FIELD_ID_W-1:0]            emit_id;
  logic [VALUE_WIDTH-1:0]                     emit_value;

  assign is_nl     = item_byte == mkvp_pkg::CH_NL;
  assign is_blank  = (item_byte == mkvp_pkg::CH_SPACE) || (item_byte == mkvp_pkg::CH_TAB);
  assign is_digit  = (item_byte >= mkvp_pkg::CH_ZERO) && (item_byte <= mkvp_pkg::CH_NINE);
  assign digit_ext = {{(VALUE_WIDTH-4){1'b0}}, item_byte[3:0]};
  assign acc_step  = (acc_r << 3) + (acc_r << 1) + digit_ext;
  assign pos_idx   = (kpos_r < mkvp_pkg::KEY_POS_W'(mkvp_pkg::MAX_KEY_LEN)) ? kpos_r : '0;

  always_comb begin
    newmask  = '0;
    done_any = 1'b0;
    done_id  = '0;
    for (int k = 0; k < mkvp_pkg::NUM_KEYS; k++) begin
      if (cmask_r[k] && (kpos_r < mkvp_pkg::KEY_LEN[k]) &&
          (mkvp_pkg::KEY_TEXT[k][pos_idx] == item_byte)) begin
        newmask[k] = 1'b1;
        if ((kpos_r + 4'd1) == mkvp_pkg::KEY_LEN[k]) begin
          done_any = 1'b1;
          done_id  = mkvp_pkg::FIELD_ID_W'(k);
        end
      end
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    kpos_nxt   = kpos_r;
    cmask_nxt  = cmask_r;
    mkey_nxt   = mkey_r;
    acc_nxt    = acc_r;
    emit       = 1'b0;
    emit_id    = mkey_r;
    emit_value = acc_r;
    unique case (phase_r)
      mkvp_pkg::PH_MATCH: begin
        if (newmask == '0) begin
          if (is_nl) begin
            kpos_nxt  = '0;
            cmask_nxt = mkvp_pkg::ALL_KEYS;
          end else begin
            phase_nxt = mkvp_pkg::PH_SKIP;
          end
        end else if (done_any) begin
          mkey_nxt  = done_id;
          acc_nxt   = '0;
          phase_nxt = mkvp_pkg::PH_BLANK;
        end else begin
          cmask_nxt = newmask;
          kpos_nxt  = kpos_r + 4'd1;
        end
      end
      mkvp_pkg::PH_BLANK, mkvp_pkg::PH_DIGIT: begin
        if ((phase_r == mkvp_pkg::PH_BLANK) && is_blank) begin
          phase_nxt = phase_r;
        end else if (is_digit) begin
          acc_nxt   = acc_step;
          phase_nxt = mkvp_pkg::PH_DIGIT;
        end else begin
          emit = 1'b1;
          if (is_nl) begin
            phase_nxt = mkvp_pkg::PH_MATCH;
            kpos_nxt  = '0;
            cmask_nxt = mkvp_pkg::ALL_KEYS;
          end else begin
            phase_nxt = mkvp_pkg::PH_SKIP;
          end
        end
      end
      mkvp_pkg::PH_SKIP: begin
        if (is_nl) begin
          phase_nxt = mkvp_pkg::PH_MATCH;
          kpos_nxt  = '0;
          cmask_nxt = mkvp_pkg::ALL_KEYS;
        end
      end
      default: begin
        phase_nxt = mkvp_pkg::PH_MATCH;
      end
    endcase

    if (item_last) begin
      if (!emit && ((phase_nxt == mkvp_pkg::PH_BLANK) || (phase_nxt == mkvp_pkg::PH_DIGIT))) begin
        emit       = 1'b1;
        emit_id    = mkey_nxt;
        emit_value = acc_nxt;
      end
      phase_nxt = mkvp_pkg::PH_MATCH;
      kpos_nxt  = '0;
      cmask_nxt = mkvp_pkg::ALL_KEYS;
    end
  end

  assign res_present       = emit || item_last;
  assign res.field_valid   = emit;
  assign res.field_id      = emit ? emit_id : '0;
  assign res.end_of_sample = item_last;
  assign res_value         = emit ? emit_value : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mkvp_pkg::PH_MATCH;
      kpos_r  <= '0;
      cmask_r <= mkvp_pkg::ALL_KEYS;
      mkey_r  <= '0;
      acc_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      kpos_r  <= kpos_nxt;
      cmask_r <= cmask_nxt;
      mkey_r  <= mkey_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

// ----- design/mkvp_out_reg.sv -----
module mkvp_out_reg #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  mkvp_pkg::result_t               res,
  input  logic [VALUE_WIDTH-1:0]          res_value,
  output logic                            free,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_field_valid,
  output logic [mkvp_pkg::FIELD_ID_W-1:0] out_field_id,
  output logic [VALUE_WIDTH-1:0]          out_field_value,
  output logic                            out_end_of_sample
);

  logic                   valid_r;
  logic                   valid_nxt;
  mkvp_pkg::result_t      res_r;
  logic [VALUE_WIDTH-1:0] value_r;

  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r   <= res;
      value_r <= res_value;
    end
  end

  assign out_valid         = valid_r;
  assign out_field_valid   = res_r.field_valid;
  assign out_field_id      = res_r.field_id;
  assign out_field_value   = value_r;
  assign out_end_of_sample = res_r.end_of_sample;

endmodule

// ----- design/meminfo_key_value_parser.sv -----
// Memory-statistics line parser. Takes one text byte per cycle when not
// stalled and emits a transaction whenever a key's value completes
// (MemTotal, MemFree, MemAvailable, SwapTotal, SwapFree as ids 0 to 4) and
// always on the final byte of the buffer, with end_of_sample set. Bytes that
// finish nothing give no transaction. Each accepted byte is held in the input
// register; the parse step that matches keys and does the multiply-by-ten-add
// works on it combinationally, and its result is captured in the output
// register. The parse state updates once per byte, setting the rate of one
// byte per cycle when not stalled. Values wrap modulo 2^VALUE_WIDTH.
module meminfo_key_value_parser #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_byte,
  input  logic                            in_last_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_field_valid,
  output logic [mkvp_pkg::FIELD_ID_W-1:0] out_field_id,
  output logic [VALUE_WIDTH-1:0]          out_field_value,
  output logic                            out_end_of_sample
);

  logic                   item_valid;
  logic [7:0]             item_byte;
  logic                   item_last;
  logic                   advance;
  logic                   res_present;
  mkvp_pkg::result_t      res;
  logic [VALUE_WIDTH-1:0] res_value;
  logic                   out_free;

  // advance the parse step unless a result must wait for the output register
  assign advance = item_valid && (!res_present || out_free);

  mkvp_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .advance      (advance),
    .item_valid   (item_valid),
    .item_byte    (item_byte),
    .item_last    (item_last)
  );

  mkvp_parser #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .item_byte   (item_byte),
    .item_last   (item_last),
    .res_present (res_present),
    .res         (res),
    .res_value   (res_value)
  );

  mkvp_out_reg #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_out_reg (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (advance && res_present),
    .res               (res),
    .res_value         (res_value),
    .free              (out_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_field_valid   (out_field_valid),
    .out_field_id      (out_field_id),
    .out_field_value   (out_field_value),
    .out_end_of_sample (out_end_of_sample)
  );

endmodule

// ----- design/mkvp_checker.sv -----
module mkvp_checker #(
  parameter int VALUE_WIDTH = 64
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_field_valid,
  input logic [mkvp_pkg::FIELD_ID_W-1:0] out_field_id,
  input logic [VALUE_WIDTH-1:0]          out_field_value,
  input logic                            out_end_of_sample
);

  // a transaction without a field is only the end-of-sample marker, all zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_field_valid) |->
      (out_end_of_sample && (out_field_id == '0) && (out_field_value == '0)))
  else $error("empty transaction is not a clean end-of-sample marker");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_field_id <= mkvp_pkg::FIELD_ID_W'(mkvp_pkg::NUM_KEYS - 1)))
  else $error("field id beyond the key list");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_field_valid) && $stable(out_field_id) &&
       $stable(out_field_value) && $stable(out_end_of_sample)))
  else $error("stalled result transaction changed");

  assert property (@(posedge clk) !rst_n |=> !out_valid)
  else $error("result valid straight after reset");

endmodule

bind meminfo_key_value_parser mkvp_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_mkvp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_field_valid   (out_field_valid),
  .out_field_id      (out_field_id),
  .out_field_value   (out_field_value),
  .out_end_of_sample (out_end_of_sample)
);
